// File: sv/rctg_pkg.sv
package rctg_pkg;

  localparam int unsigned TIMEOUT_RESET = 1000;
  localparam int unsigned GAP_RESET     = 100;

  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_GAP     = 8'd1;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_LINKER = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_COMPLETE = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_LINK_ERR = 2'd2
  } status_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] min_bytes;
    logic [7:0] max_bytes;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [6:0] byte_count;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OUT_BYTE  = 2'd0,
    OUT_EMPTY = 2'd1,
    OUT_ERROR = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic      start;
    logic      push;
    logic      tick;
    logic      rd_clear;
    logic      rd_next;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic lim_zero;
    logic end_cond;
    logic fill_zero;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

// File: sv/rctg_ctrl.sv
module rctg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rctg_pkg::func_t   in_func,
  input  rctg_pkg::sts_t    sts,
  output logic              in_stall,
  output rctg_pkg::cmd_t    cmd
);
  import rctg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COLLECT,
    S_CHECK,
    S_READ,
    S_EMIT,
    S_EMPTY,
    S_ERROR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = !((state_r == S_IDLE) || (state_r == S_COLLECT));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = OUT_BYTE;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_func == FUNC_START)) begin
          cmd.start = 1'b1;
          if (!sts.lim_zero) begin
            state_nxt = S_COLLECT;
          end
        end
      end
      S_COLLECT: begin
        if (accept) begin
          unique case (in_func)
            FUNC_START: begin
            end
            FUNC_BYTE: begin
              cmd.push  = 1'b1;
              state_nxt = S_CHECK;
            end
            FUNC_TICK: begin
              cmd.tick  = 1'b1;
              state_nxt = S_CHECK;
            end
            FUNC_LINKER: begin
              state_nxt = S_ERROR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (sts.end_cond) begin
          cmd.rd_clear = 1'b1;
          state_nxt    = sts.fill_zero ? S_EMPTY : S_READ;
        end else begin
          state_nxt = S_COLLECT;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_BYTE;
          cmd.rd_next  = 1'b1;
          state_nxt    = sts.last_byte ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_EMPTY;
          state_nxt    = S_IDLE;
        end
      end
      S_ERROR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_ERROR;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/rctg_dp.sv
module rctg_dp #(
  parameter int MAX_RESPONSE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rctg_pkg::in_item_t  in_data,
  input  rctg_pkg::cmd_t      cmd,
  input  logic                cfg_wr,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output rctg_pkg::out_item_t out_data,
  output rctg_pkg::sts_t      sts
);
  import rctg_pkg::*;

  localparam int IDX_W = (MAX_RESPONSE > 1) ? $clog2(MAX_RESPONSE) : 1;

  logic [15:0] timeout_r;
  logic [15:0] gap_r;
  logic [7:0]  need_r;
  logic [6:0]  limit_r;
  logic [6:0]  fill_r;
  logic [15:0] since_start_r;
  logic [15:0] since_last_r;
  logic [7:0]  store_mem [MAX_RESPONSE];
  logic [IDX_W-1:0] rd_idx_r;
  logic [7:0]  rd_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [7:0]  lim_raw;
  logic [6:0]  lim;
  logic        can_store;
  status_t     resp_status;
  out_item_t   out_nxt;

  assign lim_raw = (in_data.max_bytes < in_data.min_bytes) ? in_data.min_bytes
                                                           : in_data.max_bytes;
  assign lim = (lim_raw > 8'(MAX_RESPONSE)) ? 7'(MAX_RESPONSE) : lim_raw[6:0];
  assign can_store = (fill_r < limit_r) && (fill_r < 7'(MAX_RESPONSE));
  assign resp_status = ({1'b0, fill_r} >= need_r) ? STATUS_COMPLETE : STATUS_SHORT;

  assign sts.lim_zero  = (lim == 7'd0);
  assign sts.end_cond  = (fill_r >= limit_r) ||
                         ((since_start_r >= timeout_r) &&
                          ((fill_r == 7'd0) || (since_last_r >= gap_r)));
  assign sts.fill_zero = (fill_r == 7'd0);
  assign sts.last_byte = ((7'(rd_idx_r) + 7'd1) == fill_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt = '0;
    unique case (cmd.out_kind)
      OUT_BYTE: begin
        out_nxt.status     = resp_status;
        out_nxt.out_byte   = rd_data_r;
        out_nxt.byte_valid = 1'b1;
        out_nxt.byte_count = fill_r;
        out_nxt.last       = sts.last_byte;
      end
      OUT_EMPTY: begin
        out_nxt.status = resp_status;
        out_nxt.last   = 1'b1;
      end
      OUT_ERROR: begin
        out_nxt.status = STATUS_LINK_ERR;
        out_nxt.last   = 1'b1;
      end
      default: begin
        out_nxt.status = STATUS_LINK_ERR;
        out_nxt.last   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= 16'(TIMEOUT_RESET);
      gap_r         <= 16'(GAP_RESET);
      need_r        <= '0;
      limit_r       <= '0;
      fill_r        <= '0;
      since_start_r <= '0;
      since_last_r  <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_index == CFG_TIMEOUT)) begin
        timeout_r <= cfg_data;
      end
      if (cfg_wr && (cfg_index == CFG_GAP)) begin
        gap_r <= cfg_data;
      end
      if (cmd.start) begin
        need_r        <= in_data.min_bytes;
        limit_r       <= lim;
        fill_r        <= '0;
        since_start_r <= '0;
        since_last_r  <= '0;
      end
      if (cmd.push && can_store) begin
        fill_r       <= fill_r + 7'd1;
        since_last_r <= '0;
      end
      if (cmd.tick) begin
        if (since_start_r != 16'hFFFF) begin
          since_start_r <= since_start_r + 16'd1;
        end
        if (since_last_r != 16'hFFFF) begin
          since_last_r <= since_last_r + 16'd1;
        end
      end
      if (cmd.rd_clear) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_next) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && can_store) begin
      store_mem[fill_r[IDX_W-1:0]] <= in_data.rx_byte;
    end
    rd_data_r <= store_mem[rd_idx_r];
    if (cmd.out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/response_collector_timeout_gap.sv
// A start item is taken on acceptance; a received byte or tick is accepted and then goes through the end check.
// A link error result is loaded from the error state once the output is free.
// Readout of a response alternates read and emit states for each byte, as the store read port is registered.
// Input is stalled from the end check, or from a link error, until the last result is loaded into the output register.
// Reset is synchronous and active low: control state clears, timeout is 1000 and gap is 100.
// The response store is not cleared; only bytes of the current response are read.
module response_collector_timeout_gap #(
  parameter int MAX_RESPONSE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rctg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rctg_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import rctg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  rctg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rctg_dp #(
    .MAX_RESPONSE (MAX_RESPONSE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

endmodule
